FILE: src/nalinv_pkg.sv
`timescale 1ns / 1ps

package nalinv_pkg;

  localparam int PREFIX_BYTES_DEF      = 4;
  localparam int MAX_LEADING_ZEROS_DEF = 32;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_IDR  = 5'h05;
  localparam logic [4:0] NAL_TYPE_NON_IDR = 5'h01;

  // residue mod 5 of the second ue(v) field that marks an intra slice
  localparam logic [2:0] SLICE_INTRA_RES = 3'd2;

  // One input transaction: a packet byte and its end marker.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_xact_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       inverted;
    logic       last;
  } res_xact_t;

  // Reduce a value below ten modulo five.
  function automatic logic [2:0] mod5_small(input logic [3:0] v);
    logic [3:0] t;
    t = (v >= 4'd5) ? (v - 4'd5) : v;
    return t[2:0];
  endfunction

  // (2^k - 1) mod 5, indexed by k mod 4.
  function automatic logic [2:0] pow2m1_mod5(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd3;
      2'd3:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/nal_unit_intra_slice_inverter.sv
`timescale 1ns / 1ps

// Length-prefixed NAL stream filter: takes one packet byte per transaction and
// returns one byte per transaction, inverting the payload of IDR units and of
// non-IDR units whose slice kind (the second ue(v) field of the slice header) is
// intra; there the inversion begins after the byte that ends the third ue(v)
// field, or a byte later if the field ends on the byte's last bit. It sustains
// one byte per clock unless out_stall holds a result, as the per-byte parser
// update walks all eight bits combinationally between the input and output
// registers. A held result stalls the input as well. packet_end returns all
// parser state to the start of a length prefix once its byte is processed.
module nal_unit_intra_slice_inverter #(
  parameter int PREFIX_BYTES      = nalinv_pkg::PREFIX_BYTES_DEF,
  parameter int MAX_LEADING_ZEROS = nalinv_pkg::MAX_LEADING_ZEROS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_packet_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_was_inverted,
  output logic       out_last
);

  logic                   advance;
  logic                   s1_valid;
  nalinv_pkg::byte_xact_t in_xact;
  nalinv_pkg::byte_xact_t s1_xact;
  nalinv_pkg::res_xact_t  core_res;
  nalinv_pkg::res_xact_t  out_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;

  // advance the whole pipe unless a held result is still waiting
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  assign in_xact.data = in_data_byte;
  assign in_xact.last = in_packet_end;

  nalinv_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .in_xact  (in_xact),
    .s1_valid (s1_valid),
    .s1_xact  (s1_xact)
  );

  nalinv_core #(
    .PREFIX_BYTES      (PREFIX_BYTES),
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance && s1_valid),
    .xact  (s1_xact),
    .res   (core_res)
  );

  assign out_valid_nxt = advance ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_r <= core_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_r.data;
  assign out_was_inverted = out_r.inverted;
  assign out_last         = out_r.last;

endmodule

FILE: src/nalinv_in_stage.sv
`timescale 1ns / 1ps

module nalinv_in_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    in_valid,
  input  nalinv_pkg::byte_xact_t  in_xact,
  output logic                    s1_valid,
  output nalinv_pkg::byte_xact_t  s1_xact
);

  logic                   valid_r;
  logic                   valid_nxt;
  nalinv_pkg::byte_xact_t xact_r;

  assign valid_nxt = advance ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold the payload while the pipe is stalled
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      xact_r <= in_xact;
    end
  end

  assign s1_valid = valid_r;
  assign s1_xact  = xact_r;

endmodule

FILE: src/nalinv_core.sv
`timescale 1ns / 1ps

module nalinv_core #(
  parameter int PREFIX_BYTES      = nalinv_pkg::PREFIX_BYTES_DEF,
  parameter int MAX_LEADING_ZEROS = nalinv_pkg::MAX_LEADING_ZEROS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  nalinv_pkg::byte_xact_t xact,
  output nalinv_pkg::res_xact_t  res
);

  localparam int LEN_W = 8 * PREFIX_BYTES;
  localparam int PC_W  = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam int LZ_W  = (MAX_LEADING_ZEROS < 3) ? 2 : $clog2(MAX_LEADING_ZEROS + 1);

  typedef enum logic [4:0] {
    PH_LEN    = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_PARSE  = 5'b00100,
    PH_INVERT = 5'b01000,
    PH_PASS   = 5'b10000
  } phase_t;

  phase_t            phase_r,  phase_nxt;
  logic [PC_W-1:0]   pcnt_r,   pcnt_nxt;
  logic [LEN_W-1:0]  len_r,    len_nxt;
  logic [1:0]        elem_r,   elem_nxt;
  logic [LZ_W-1:0]   lz_r,     lz_nxt;
  logic              insfx_r,  insfx_nxt;
  logic [LZ_W-1:0]   sbl_r,    sbl_nxt;
  logic [2:0]        res5_r,   res5_nxt;
  logic              skip_r,   skip_nxt;
  logic              inv;

  always_comb begin
    logic [LEN_W-1:0] acc;
    logic [4:0]       nal_type;
    logic             stop;
    logic             done;
    logic             bitv;
    phase_t           ph;
    logic [1:0]       elem;
    logic [LZ_W-1:0]  lz;
    logic             insfx;
    logic [LZ_W-1:0]  sbl;
    logic [2:0]       r5;
    logic             skp;

    phase_nxt = phase_r;
    pcnt_nxt  = pcnt_r;
    len_nxt   = len_r;
    elem_nxt  = elem_r;
    lz_nxt    = lz_r;
    insfx_nxt = insfx_r;
    sbl_nxt   = sbl_r;
    res5_nxt  = res5_r;
    skip_nxt  = skip_r;
    inv       = 1'b0;

    acc      = (len_r << 8) | LEN_W'(xact.data);
    nal_type = xact.data[4:0] & nalinv_pkg::NAL_TYPE_MASK;
    stop     = 1'b0;
    done     = 1'b0;
    bitv     = 1'b0;
    ph       = phase_r;
    elem     = elem_r;
    lz       = lz_r;
    insfx    = insfx_r;
    sbl      = sbl_r;
    r5       = res5_r;
    skp      = skip_r;

    case (phase_r)
      PH_LEN: begin
        len_nxt = acc;
        if (pcnt_r == PC_W'(PREFIX_BYTES - 1)) begin
          pcnt_nxt = '0;
          if (acc != '0) begin
            phase_nxt = PH_HEADER;
            elem_nxt  = '0;
            lz_nxt    = '0;
            insfx_nxt = 1'b0;
            sbl_nxt   = '0;
            res5_nxt  = '0;
            skip_nxt  = 1'b0;
          end
        end else begin
          pcnt_nxt = pcnt_r + PC_W'(1);
        end
      end
      PH_HEADER: begin
        if (nal_type == nalinv_pkg::NAL_TYPE_IDR) begin
          phase_nxt = PH_INVERT;
        end else if (nal_type == nalinv_pkg::NAL_TYPE_NON_IDR) begin
          phase_nxt = PH_PARSE;
        end else begin
          phase_nxt = PH_PASS;
        end
      end
      PH_PARSE: begin
        // walk the byte MSB first through the ue(v) bit parser
        for (int pos = 7; pos >= 0; pos--) begin
          if (!stop) begin
            bitv = xact.data[pos];
            done = 1'b0;
            if (!insfx) begin
              if (!bitv) begin
                if (lz >= LZ_W'(MAX_LEADING_ZEROS)) begin
                  ph   = PH_PASS;
                  stop = 1'b1;
                end else begin
                  lz = lz + LZ_W'(1);
                end
              end else if (lz == '0) begin
                done = 1'b1;
              end else begin
                insfx = 1'b1;
                sbl   = lz;
              end
            end else begin
              if (elem == 2'd1) begin
                r5 = nalinv_pkg::mod5_small({r5, bitv});
              end
              sbl = sbl - LZ_W'(1);
              if (sbl == '0) begin
                if (elem == 2'd1) begin
                  r5 = nalinv_pkg::mod5_small(
                    4'(r5) + 4'(nalinv_pkg::pow2m1_mod5(lz[1:0])));
                end
                done = 1'b1;
              end
            end
            if (done && !stop) begin
              lz    = '0;
              insfx = 1'b0;
              sbl   = '0;
              if (elem >= 2'd2) begin
                if (r5 == nalinv_pkg::SLICE_INTRA_RES) begin
                  ph  = PH_INVERT;
                  skp = (pos == 0);
                end else begin
                  ph = PH_PASS;
                end
                stop = 1'b1;
              end else begin
                elem = elem + 2'd1;
              end
            end
          end
        end
        phase_nxt = ph;
        elem_nxt  = elem;
        lz_nxt    = lz;
        insfx_nxt = insfx;
        sbl_nxt   = sbl;
        res5_nxt  = r5;
        skip_nxt  = skp;
      end
      PH_INVERT: begin
        if (skip_r) begin
          skip_nxt = 1'b0;
        end else begin
          inv = 1'b1;
        end
      end
      PH_PASS: begin
      end
      default: begin
        phase_nxt = PH_LEN;
      end
    endcase

    if (phase_r != PH_LEN) begin
      len_nxt = len_r - LEN_W'(1);
      if (len_nxt == '0) begin
        phase_nxt = PH_LEN;
        pcnt_nxt  = '0;
        elem_nxt  = '0;
        lz_nxt    = '0;
        insfx_nxt = 1'b0;
        sbl_nxt   = '0;
        res5_nxt  = '0;
        skip_nxt  = 1'b0;
      end
    end

    // drop everything at the end of a packet
    if (xact.last) begin
      phase_nxt = PH_LEN;
      pcnt_nxt  = '0;
      len_nxt   = '0;
      elem_nxt  = '0;
      lz_nxt    = '0;
      insfx_nxt = 1'b0;
      sbl_nxt   = '0;
      res5_nxt  = '0;
      skip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      pcnt_r  <= '0;
      len_r   <= '0;
      elem_r  <= '0;
      lz_r    <= '0;
      insfx_r <= 1'b0;
      sbl_r   <= '0;
      res5_r  <= '0;
      skip_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pcnt_r  <= pcnt_nxt;
      len_r   <= len_nxt;
      elem_r  <= elem_nxt;
      lz_r    <= lz_nxt;
      insfx_r <= insfx_nxt;
      sbl_r   <= sbl_nxt;
      res5_r  <= res5_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign res.data     = inv ? ~xact.data : xact.data;
  assign res.inverted = inv;
  assign res.last     = xact.last;

endmodule
